[src/segment_allocator_fit_policy_unit_macros.svh]
// Assertion macros for the segment allocator checker.
`ifndef SEGMENT_ALLOCATOR_FIT_POLICY_UNIT_MACROS_SVH
`define SEGMENT_ALLOCATOR_FIT_POLICY_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define SAP_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SAP_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/sap_pkg.sv]
package sap_pkg;

  localparam int MAX_SEG  = 32;
  localparam int MAX_HOLE = 32;
  localparam int ADDR_W   = 20;
  localparam int SIZE_W   = 20;
  // hole sizes can grow through merges, keep headroom
  localparam int HSZ_W    = 26;
  localparam int TOT_W    = 32;
  localparam int IDX_W    = $clog2(MAX_SEG);
  localparam int CNT_W    = $clog2(MAX_SEG + 1);

  localparam logic [SIZE_W-1:0] RST_MEM = SIZE_W'(4096);
  localparam logic [SIZE_W-1:0] RST_SHR = SIZE_W'(128);

  localparam logic [1:0] OP_CREATE  = 2'd0;
  localparam logic [1:0] OP_DELETE  = 2'd1;
  localparam logic [1:0] OP_COMPACT = 2'd2;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  localparam logic [1:0] CFG_POL = 2'd0;
  localparam logic [1:0] CFG_MEM = 2'd1;
  localparam logic [1:0] CFG_SHR = 2'd2;

  localparam logic [2:0] ST_CREATED   = 3'd0;
  localparam logic [2:0] ST_DELETED   = 3'd1;
  localparam logic [2:0] ST_CNEED     = 3'd2;
  localparam logic [2:0] ST_OOM       = 3'd3;
  localparam logic [2:0] ST_NOTFOUND  = 3'd4;
  localparam logic [2:0] ST_COMPACTED = 3'd5;
  localparam logic [2:0] ST_FULL      = 3'd6;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [3:0]        segment_id;
    logic [7:0]        process_id;
    logic [SIZE_W-1:0] request_size;
  } sap_req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [7:0]        out_process_id;
    logic [3:0]        out_segment_id;
    logic [ADDR_W-1:0] base_address;
    logic [SIZE_W-1:0] segment_size;
    logic              last;
  } sap_rsp_t;

  typedef struct packed {
    logic [7:0]        pid;
    logic [3:0]        id;
    logic [ADDR_W-1:0] base;
    logic [SIZE_W-1:0] size;
  } sap_seg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [HSZ_W-1:0]  size;
  } sap_hole_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_REMOVE,
    CELL_INSERT,
    CELL_MERGE,
    CELL_SORT
  } sap_cell_op_t;

  typedef struct packed {
    sap_cell_op_t     op;
    logic [IDX_W-1:0] pos;
    logic [CNT_W-1:0] cnt;
    logic             phase;
    sap_seg_t         data;
  } sap_seg_cmd_t;

  typedef struct packed {
    sap_cell_op_t     op;
    logic [IDX_W-1:0] pos;
    sap_hole_t        data;
  } sap_hole_cmd_t;

endpackage

[src/sap_seg_cell.sv]
module sap_seg_cell import sap_pkg::*; (
  input  logic             clk,
  input  logic [IDX_W-1:0] idx,
  input  sap_seg_cmd_t     cmd,
  input  sap_seg_t         left,
  input  sap_seg_t         right,
  output sap_seg_t         q
);

  sap_seg_t         q_next;
  logic [CNT_W-1:0] idx_ext;

  assign idx_ext = CNT_W'(idx);

  always_comb begin
    q_next = q;
    case (cmd.op)
      CELL_WRITE: begin
        if (idx == cmd.pos) q_next = cmd.data;
      end
      CELL_REMOVE: begin
        if (idx >= cmd.pos) q_next = right;
      end
      CELL_INSERT: begin
        if (idx > cmd.pos) q_next = left;
        else if (idx == cmd.pos) q_next = cmd.data;
      end
      CELL_SORT: begin
        // odd-even transposition: strict compare keeps equal bases in order
        if (idx[0] == cmd.phase) begin
          if ((idx_ext + CNT_W'(1) < cmd.cnt) && (q.base > right.base)) q_next = right;
        end else begin
          if ((idx_ext != '0) && (idx_ext < cmd.cnt) && (left.base > q.base)) q_next = left;
        end
      end
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

[src/sap_hole_cell.sv]
module sap_hole_cell import sap_pkg::*; (
  input  logic             clk,
  input  logic [IDX_W-1:0] idx,
  input  sap_hole_cmd_t    cmd,
  input  sap_hole_t        left,
  input  sap_hole_t        right,
  output sap_hole_t        q
);

  sap_hole_t q_next;

  always_comb begin
    q_next = q;
    case (cmd.op)
      CELL_WRITE: begin
        if (idx == cmd.pos) q_next = cmd.data;
      end
      CELL_REMOVE: begin
        if (idx >= cmd.pos) q_next = right;
      end
      CELL_INSERT: begin
        if (idx > cmd.pos) q_next = left;
        else if (idx == cmd.pos) q_next = cmd.data;
      end
      CELL_MERGE: begin
        // pos-1 takes the merged hole, pos and up close the gap
        if (idx >= cmd.pos) q_next = right;
        else if ({1'b0, idx} + 1'b1 == {1'b0, cmd.pos}) q_next = cmd.data;
      end
      default: q_next = q;
    endcase
  end

  always_ff @(posedge clk) begin
    q <= q_next;
  end

endmodule

[src/segment_allocator_fit_policy_unit.sv]
// channel | signals                         | payload
// req     | req_valid, req_ready            | sap_req_t
// rsp     | rsp_valid, rsp_ready            | sap_rsp_t
// cfg     | cfg_valid, cfg_ready (always 1) | cfg_index, cfg_data
// One request at a time. Create scans the holes; delete scans the segments, then
// the holes; compact sorts the segments, walks them once, then writes the tail hole.
// Reset (sync, high) restores the default layout at once; no clearing pass.
// Results sit in an output register; the next request is taken while it waits.
// A stalled rsp holds the compact walk and the single-result send.
module segment_allocator_fit_policy_unit import sap_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  sap_req_t   req,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output sap_rsp_t   rsp,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [SIZE_W-1:0] cfg_data
);

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_CSCAN  = 10'b0000000010,
    S_CDONE  = 10'b0000000100,
    S_DSEG   = 10'b0000001000,
    S_DHOLE  = 10'b0000010000,
    S_DAPPLY = 10'b0000100000,
    S_SORT   = 10'b0001000000,
    S_CWALK  = 10'b0010000000,
    S_CFIN   = 10'b0100000000,
    S_EMIT   = 10'b1000000000
  } state_t;

  state_t            state;
  logic [CNT_W-1:0]  seg_cnt, hole_cnt, ctr, hole_p;
  logic [1:0]        pol;
  logic [SIZE_W-1:0] mem_size, shr_size;
  logic [7:0]        cur_pid;
  logic [3:0]        cur_id;
  logic [SIZE_W-1:0] cur_req;
  logic [TOT_W-1:0]  total;
  logic              found;
  logic [IDX_W-1:0]  pick_idx, sel_idx;
  logic [ADDR_W-1:0] pick_base;
  logic [HSZ_W-1:0]  pick_size;
  sap_seg_t          sel;
  sap_hole_t         prev_h;
  logic [HSZ_W-1:0]  run;
  sap_rsp_t          res;

  sap_seg_t      seg_q [MAX_SEG];
  sap_seg_t      seg_l [MAX_SEG];
  sap_seg_t      seg_r [MAX_SEG];
  sap_hole_t     hole_q [MAX_HOLE];
  sap_hole_t     hole_l [MAX_HOLE];
  sap_hole_t     hole_r [MAX_HOLE];
  sap_seg_cmd_t  scmd;
  sap_hole_cmd_t hcmd;

  for (genvar k = 0; k < MAX_SEG; k++) begin : g_seg
    if (k == 0) begin : g_first
      assign seg_l[k] = '0;
    end else begin : g_mid
      assign seg_l[k] = seg_q[k-1];
    end
    if (k == MAX_SEG - 1) begin : g_end
      assign seg_r[k] = '0;
    end else begin : g_inner
      assign seg_r[k] = seg_q[k+1];
    end
    sap_seg_cell u_cell (
      .clk   (clk),
      .idx   (IDX_W'(k)),
      .cmd   (scmd),
      .left  (seg_l[k]),
      .right (seg_r[k]),
      .q     (seg_q[k])
    );
  end

  for (genvar k = 0; k < MAX_HOLE; k++) begin : g_hole
    if (k == 0) begin : g_first
      assign hole_l[k] = '0;
    end else begin : g_mid
      assign hole_l[k] = hole_q[k-1];
    end
    if (k == MAX_HOLE - 1) begin : g_end
      assign hole_r[k] = '0;
    end else begin : g_inner
      assign hole_r[k] = hole_q[k+1];
    end
    sap_hole_cell u_cell (
      .clk   (clk),
      .idx   (IDX_W'(k)),
      .cmd   (hcmd),
      .left  (hole_l[k]),
      .right (hole_r[k]),
      .q     (hole_q[k])
    );
  end

  sap_seg_t          srd;
  sap_hole_t         hrd, hp;
  logic              ofree, lay, rsp_load;
  logic [SIZE_W-1:0] lay_mem, lay_shr;
  logic [HSZ_W-1:0]  req_ext, prev_end, sel_size_ext;
  logic [ADDR_W-1:0] sel_end;
  logic              prev_adj, next_adj, del_ok, cfg_wr;

  assign srd          = seg_q[ctr[IDX_W-1:0]];
  assign hrd          = hole_q[ctr[IDX_W-1:0]];
  assign hp           = hole_q[hole_p[IDX_W-1:0]];
  assign ofree        = !rsp_valid || rsp_ready;
  assign rsp_load     = ofree && ((state == S_EMIT)
                        || ((state == S_CWALK) && (ctr < seg_cnt)));
  assign req_ext      = HSZ_W'(cur_req);
  assign sel_size_ext = HSZ_W'(sel.size);
  assign prev_end     = HSZ_W'(prev_h.base) + prev_h.size;
  assign sel_end      = sel.base + sel.size;
  assign prev_adj     = (hole_p != '0) && (prev_end[ADDR_W-1:0] == sel.base);
  assign next_adj     = (hole_p < hole_cnt) && (sel_end == hp.base);
  assign del_ok       = (sel.size == '0) || prev_adj || next_adj
                        || (hole_cnt < CNT_W'(MAX_HOLE));
  assign req_ready    = (state == S_IDLE);
  assign cfg_ready    = 1'b1;
  assign cfg_wr       = cfg_valid && cfg_ready;

  always_comb begin
    lay_mem = mem_size;
    lay_shr = shr_size;
    lay     = 1'b0;
    if (rst) begin
      lay_mem = RST_MEM;
      lay_shr = RST_SHR;
      lay     = 1'b1;
    end else if (cfg_wr && (cfg_index == CFG_MEM)) begin
      lay_mem = cfg_data;
      lay     = 1'b1;
    end else if (cfg_wr && (cfg_index == CFG_SHR)) begin
      lay_shr = cfg_data;
      lay     = 1'b1;
    end
  end

  always_comb begin
    scmd    = '0;
    scmd.op = CELL_HOLD;
    hcmd    = '0;
    hcmd.op = CELL_HOLD;
    if (lay) begin
      scmd.op        = CELL_WRITE;
      scmd.data.size = lay_shr;
      hcmd.op        = CELL_WRITE;
      hcmd.data.base = lay_shr;
      hcmd.data.size = HSZ_W'(lay_mem - lay_shr);
    end else begin
      case (state)
        S_CDONE: begin
          if (found) begin
            scmd.op   = CELL_WRITE;
            scmd.pos  = seg_cnt[IDX_W-1:0];
            scmd.data = '{pid: cur_pid, id: cur_id, base: pick_base, size: cur_req};
            if (cur_req != '0) begin
              hcmd.pos = pick_idx;
              if (pick_size == req_ext) begin
                hcmd.op = CELL_REMOVE;
              end else begin
                hcmd.op        = CELL_WRITE;
                hcmd.data.base = pick_base + cur_req;
                hcmd.data.size = pick_size - req_ext;
              end
            end
          end
        end
        S_DAPPLY: begin
          if (del_ok) begin
            scmd.op  = CELL_REMOVE;
            scmd.pos = sel_idx;
            if (sel.size != '0) begin
              hcmd.pos = hole_p[IDX_W-1:0];
              if (prev_adj && next_adj) begin
                hcmd.op        = CELL_MERGE;
                hcmd.data.base = prev_h.base;
                hcmd.data.size = prev_h.size + sel_size_ext + hp.size;
              end else if (prev_adj) begin
                hcmd.op        = CELL_WRITE;
                hcmd.pos       = hole_p[IDX_W-1:0] - 1'b1;
                hcmd.data.base = prev_h.base;
                hcmd.data.size = prev_h.size + sel_size_ext;
              end else if (next_adj) begin
                hcmd.op        = CELL_WRITE;
                hcmd.data.base = sel.base;
                hcmd.data.size = hp.size + sel_size_ext;
              end else begin
                hcmd.op        = CELL_INSERT;
                hcmd.data.base = sel.base;
                hcmd.data.size = sel_size_ext;
              end
            end
          end
        end
        S_SORT: begin
          scmd.op    = CELL_SORT;
          scmd.cnt   = seg_cnt;
          scmd.phase = ctr[0];
        end
        S_CWALK: begin
          if ((ctr < seg_cnt) && ofree) begin
            scmd.op        = CELL_WRITE;
            scmd.pos       = ctr[IDX_W-1:0];
            scmd.data      = srd;
            scmd.data.base = run[ADDR_W-1:0];
          end
        end
        S_CFIN: begin
          if (run < HSZ_W'(mem_size)) begin
            hcmd.op        = CELL_WRITE;
            hcmd.data.base = run[ADDR_W-1:0];
            hcmd.data.size = HSZ_W'(mem_size) - run;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
      seg_cnt   <= CNT_W'(1);
      hole_cnt  <= CNT_W'(RST_SHR < RST_MEM);
      pol       <= POL_FIRST;
      mem_size  <= RST_MEM;
      shr_size  <= RST_SHR;
    end else begin
      if (rsp_load) rsp_valid <= 1'b1;
      else if (rsp_valid && rsp_ready) rsp_valid <= 1'b0;
      if (cfg_wr) begin
        case (cfg_index)
          CFG_POL: pol <= cfg_data[1:0];
          CFG_MEM: begin
            mem_size <= cfg_data;
            seg_cnt  <= CNT_W'(1);
            hole_cnt <= CNT_W'(shr_size < cfg_data);
          end
          CFG_SHR: begin
            shr_size <= cfg_data;
            seg_cnt  <= CNT_W'(1);
            hole_cnt <= CNT_W'(cfg_data < mem_size);
          end
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            cur_pid <= req.process_id;
            cur_id  <= req.segment_id;
            cur_req <= req.request_size;
            ctr     <= '0;
            total   <= '0;
            found   <= 1'b0;
            case (req.opcode)
              OP_CREATE: begin
                if (seg_cnt == CNT_W'(MAX_SEG)) begin
                  res   <= '{status: ST_FULL, out_process_id: req.process_id,
                             out_segment_id: req.segment_id, base_address: '0,
                             segment_size: req.request_size, last: 1'b1};
                  state <= S_EMIT;
                end else begin
                  state <= S_CSCAN;
                end
              end
              OP_DELETE:  state <= S_DSEG;
              OP_COMPACT: state <= S_SORT;
              default:    state <= S_IDLE;
            endcase
          end
        end
        S_CSCAN: begin
          if (ctr < hole_cnt) begin
            total <= total + TOT_W'(hrd.size);
            if (hrd.size >= req_ext) begin
              case (pol)
                POL_BEST: begin
                  if (!found || (hrd.size < pick_size)) begin
                    found     <= 1'b1;
                    pick_idx  <= ctr[IDX_W-1:0];
                    pick_base <= hrd.base;
                    pick_size <= hrd.size;
                  end
                end
                POL_WORST: begin
                  if (!found || (hrd.size > pick_size)) begin
                    found     <= 1'b1;
                    pick_idx  <= ctr[IDX_W-1:0];
                    pick_base <= hrd.base;
                    pick_size <= hrd.size;
                  end
                end
                default: begin
                  if (!found) begin
                    found     <= 1'b1;
                    pick_idx  <= ctr[IDX_W-1:0];
                    pick_base <= hrd.base;
                    pick_size <= hrd.size;
                  end
                end
              endcase
            end
            ctr <= ctr + 1'b1;
          end else begin
            state <= S_CDONE;
          end
        end
        S_CDONE: begin
          res.out_process_id <= cur_pid;
          res.out_segment_id <= cur_id;
          res.segment_size   <= cur_req;
          res.last           <= 1'b1;
          if (found) begin
            seg_cnt <= seg_cnt + 1'b1;
            if ((cur_req != '0) && (pick_size == req_ext)) hole_cnt <= hole_cnt - 1'b1;
            res.status       <= ST_CREATED;
            res.base_address <= pick_base;
          end else begin
            res.status       <= (total >= TOT_W'(cur_req)) ? ST_CNEED : ST_OOM;
            res.base_address <= '0;
          end
          state <= S_EMIT;
        end
        S_DSEG: begin
          if (ctr < seg_cnt) begin
            if ((srd.pid == cur_pid) && (srd.id == cur_id)) begin
              sel     <= srd;
              sel_idx <= ctr[IDX_W-1:0];
              hole_p  <= '0;
              state   <= S_DHOLE;
            end else begin
              ctr <= ctr + 1'b1;
            end
          end else begin
            res   <= '{status: ST_NOTFOUND, out_process_id: cur_pid,
                       out_segment_id: cur_id, base_address: '0,
                       segment_size: '0, last: 1'b1};
            state <= S_EMIT;
          end
        end
        S_DHOLE: begin
          // find first hole above the freed base, keep the one below it
          if ((sel.size != '0) && (hole_p < hole_cnt) && (hp.base <= sel.base)) begin
            prev_h <= hp;
            hole_p <= hole_p + 1'b1;
          end else begin
            state <= S_DAPPLY;
          end
        end
        S_DAPPLY: begin
          res.out_process_id <= cur_pid;
          res.out_segment_id <= cur_id;
          res.base_address   <= sel.base;
          res.segment_size   <= sel.size;
          res.last           <= 1'b1;
          if (del_ok) begin
            seg_cnt    <= seg_cnt - 1'b1;
            res.status <= ST_DELETED;
            if (sel.size != '0) begin
              if (prev_adj && next_adj) hole_cnt <= hole_cnt - 1'b1;
              else if (!prev_adj && !next_adj) hole_cnt <= hole_cnt + 1'b1;
            end
          end else begin
            res.status <= ST_FULL;
          end
          state <= S_EMIT;
        end
        S_SORT: begin
          if (ctr == CNT_W'(MAX_SEG - 1)) begin
            ctr   <= '0;
            run   <= '0;
            state <= S_CWALK;
          end else begin
            ctr <= ctr + 1'b1;
          end
        end
        S_CWALK: begin
          if (ctr < seg_cnt) begin
            if (ofree) begin
              rsp <= '{status: ST_COMPACTED, out_process_id: srd.pid,
                       out_segment_id: srd.id, base_address: run[ADDR_W-1:0],
                       segment_size: srd.size,
                       last: (ctr + 1'b1 == seg_cnt)};
              run <= run + HSZ_W'(srd.size);
              ctr <= ctr + 1'b1;
            end
          end else begin
            state <= S_CFIN;
          end
        end
        S_CFIN: begin
          hole_cnt <= CNT_W'(run < HSZ_W'(mem_size));
          if (seg_cnt == '0) begin
            res   <= '{status: ST_COMPACTED, out_process_id: '0,
                       out_segment_id: '0, base_address: '0,
                       segment_size: '0, last: 1'b1};
            state <= S_EMIT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_EMIT: begin
          if (ofree) begin
            rsp   <= res;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[src/sap_checker.sv]
`include "segment_allocator_fit_policy_unit_macros.svh"

module sap_checker import sap_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input sap_req_t   req,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input sap_rsp_t   rsp
);

  // a real request leaves the block busy in the next cycle
  `SAP_ASSERT_NXT(a_busy_after_req, clk, rst,
    req_valid && req_ready && (req.opcode == OP_CREATE || req.opcode == OP_DELETE
    || req.opcode == OP_COMPACT), !req_ready, "ready high right after a request")

  // only compaction produces multi-item answers
  `SAP_ASSERT_IMP(a_single_last, clk, rst, rsp_valid && (rsp.status != ST_COMPACTED),
    rsp.last, "non-compact result without last")

  `SAP_ASSERT_IMP(a_status_range, clk, rst, rsp_valid, rsp.status <= ST_FULL,
    "status code out of range")

  `SAP_ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready,
    rsp_valid && $stable(rsp), "stalled result changed")

  // failed creates and not-found deletes never report a base
  `SAP_ASSERT_IMP(a_fail_base, clk, rst, rsp_valid && (rsp.status == ST_CNEED
    || rsp.status == ST_OOM || rsp.status == ST_NOTFOUND), rsp.base_address == '0,
    "failure with nonzero base")

endmodule

bind segment_allocator_fit_policy_unit sap_checker u_sap_checker (.*);
